[hdl/gmp_pkg.sv]
// Shared widths, constants, register indexes and configuration type for the gradient map.
package gmp_pkg;

    localparam int PIX_W       = 8;
    localparam int GAIN_W      = 16;
    localparam int OFFSET_W    = 16;
    localparam int SUM_W       = 10;
    localparam int LEVEL_W     = 17;
    localparam int PROD_W      = LEVEL_W + 1 + GAIN_W;
    localparam int RECIP_W     = 27;
    localparam int RECIP_SHIFT = 20;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // ceil(2^36 / 765): exact floor(sum * 65536 / 765) for sum up to 765
    localparam logic [RECIP_W-1:0] RECIP     = 27'd89829382;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] REG_START_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_RED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_GREEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_BLUE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd7;

    typedef struct packed {
        logic        [PIX_W-1:0]    start_red;
        logic        [PIX_W-1:0]    start_green;
        logic        [PIX_W-1:0]    start_blue;
        logic        [PIX_W-1:0]    end_red;
        logic        [PIX_W-1:0]    end_green;
        logic        [PIX_W-1:0]    end_blue;
        logic signed [GAIN_W-1:0]   gain;
        logic signed [OFFSET_W-1:0] offset;
    } gmp_cfg_t;

endpackage

[hdl/gmp_cfg.sv]
// Configuration register file for the gradient map.
module gmp_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gmp_pkg::CFG_DATA_W-1:0] cfg_data,
    output gmp_pkg::gmp_cfg_t              cfg
);
    import gmp_pkg::*;

    gmp_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_red   <= '0;
            cfg_reg.start_green <= '0;
            cfg_reg.start_blue  <= '0;
            cfg_reg.end_red     <= '1;
            cfg_reg.end_green   <= '1;
            cfg_reg.end_blue    <= '1;
            cfg_reg.gain        <= 16'sd256;
            cfg_reg.offset      <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_START_RED:   cfg_reg.start_red   <= cfg_data[PIX_W-1:0];
                REG_START_GREEN: cfg_reg.start_green <= cfg_data[PIX_W-1:0];
                REG_START_BLUE:  cfg_reg.start_blue  <= cfg_data[PIX_W-1:0];
                REG_END_RED:     cfg_reg.end_red     <= cfg_data[PIX_W-1:0];
                REG_END_GREEN:   cfg_reg.end_green   <= cfg_data[PIX_W-1:0];
                REG_END_BLUE:    cfg_reg.end_blue    <= cfg_data[PIX_W-1:0];
                REG_GAIN:        cfg_reg.gain        <= cfg_data[GAIN_W-1:0];
                REG_OFFSET:      cfg_reg.offset      <= cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

[hdl/gmp_level.sv]
// Brightness pipeline: channel sum, scale to 1.16, gain, offset and clamp.
module gmp_level (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic signed [gmp_pkg::GAIN_W-1:0]   gain,
    input  logic signed [gmp_pkg::OFFSET_W-1:0] offset,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [gmp_pkg::PIX_W-1:0]           in_red,
    input  logic [gmp_pkg::PIX_W-1:0]           in_green,
    input  logic [gmp_pkg::PIX_W-1:0]           in_blue,
    output logic                               lvl_valid,
    input  logic                               lvl_ready,
    output logic [gmp_pkg::LEVEL_W-1:0]         lvl
);
    import gmp_pkg::*;

    localparam int BRIGHT_FULL_W = SUM_W + RECIP_W;
    localparam int SCALED_W      = PROD_W - 8;
    localparam int TOTAL_W       = SCALED_W + 2;

    logic                      sum_vld_reg, bright_vld_reg, prod_vld_reg, lvl_vld_reg;
    logic                      adv_sum, adv_bright, adv_prod, adv_lvl;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic [LEVEL_W-1:0]        bright_reg, bright_next;
    logic [BRIGHT_FULL_W-1:0]  bright_full;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [TOTAL_W-1:0] total;
    logic [LEVEL_W-1:0]        lvl_reg, lvl_next;

    assign adv_lvl    = !lvl_vld_reg    || lvl_ready;
    assign adv_prod   = !prod_vld_reg   || adv_lvl;
    assign adv_bright = !bright_vld_reg || adv_prod;
    assign adv_sum    = !sum_vld_reg    || adv_bright;
    assign in_ready   = adv_sum;

    assign sum_next = {2'b00, in_red} + {2'b00, in_green} + {2'b00, in_blue};

    assign bright_full = {{RECIP_W{1'b0}}, sum_reg} * {{SUM_W{1'b0}}, RECIP};
    assign bright_next = bright_full[RECIP_SHIFT +: LEVEL_W];

    assign prod_next = $signed({1'b0, bright_reg}) * gain;

    // arithmetic shift gives floor toward minus infinity
    assign scaled = prod_reg[PROD_W-1:8];
    assign total  = {{2{scaled[SCALED_W-1]}}, scaled}
                  + {{(TOTAL_W-OFFSET_W-4){offset[OFFSET_W-1]}}, offset, 4'b0000};

    always_comb begin
        priority if (total[TOTAL_W-1]) begin
            lvl_next = '0;
        end else if (total > $signed({{(TOTAL_W-LEVEL_W){1'b0}}, LEVEL_ONE})) begin
            lvl_next = LEVEL_ONE;
        end else begin
            lvl_next = total[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_vld_reg    <= 1'b0;
            bright_vld_reg <= 1'b0;
            prod_vld_reg   <= 1'b0;
            lvl_vld_reg    <= 1'b0;
        end else begin
            if (adv_sum)    sum_vld_reg    <= in_valid;
            if (adv_bright) bright_vld_reg <= sum_vld_reg;
            if (adv_prod)   prod_vld_reg   <= bright_vld_reg;
            if (adv_lvl)    lvl_vld_reg    <= prod_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_sum)    sum_reg    <= sum_next;
        if (adv_bright) bright_reg <= bright_next;
        if (adv_prod)   prod_reg   <= prod_next;
        if (adv_lvl)    lvl_reg    <= lvl_next;
    end

    assign lvl_valid = lvl_vld_reg;
    assign lvl       = lvl_reg;

endmodule

[hdl/gmp_blend.sv]
// Colour blend stage and output register.
module gmp_blend (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  gmp_pkg::gmp_cfg_t          cfg,
    input  logic                       lvl_valid,
    output logic                       lvl_ready,
    input  logic [gmp_pkg::LEVEL_W-1:0] lvl,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gmp_pkg::PIX_W-1:0]  out_red,
    output logic [gmp_pkg::PIX_W-1:0]  out_green,
    output logic [gmp_pkg::PIX_W-1:0]  out_blue
);
    import gmp_pkg::*;

    localparam int DIFF_W = PIX_W + 1;
    localparam int MUL_W  = DIFF_W + LEVEL_W + 1;
    localparam int STEP_W = MUL_W - 16;

    // start + floor(level * (end - start) / 65536)
    function automatic logic [PIX_W-1:0] mix(input logic [PIX_W-1:0] s,
                                             input logic [PIX_W-1:0] e,
                                             input logic [LEVEL_W-1:0] l);
        logic signed [DIFF_W-1:0] diff;
        logic signed [MUL_W-1:0]  mul;
        logic signed [STEP_W-1:0] step;
        logic signed [STEP_W-1:0] sum;
        diff = $signed({1'b0, e}) - $signed({1'b0, s});
        mul  = diff * $signed({1'b0, l});
        step = mul[MUL_W-1:16];
        sum  = step + $signed({{(STEP_W-PIX_W){1'b0}}, s});
        return sum[PIX_W-1:0];
    endfunction

    logic             vld_reg, adv;
    logic [PIX_W-1:0] red_reg, green_reg, blue_reg;

    assign adv       = !vld_reg || out_ready;
    assign lvl_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= lvl_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            red_reg   <= mix(cfg.start_red,   cfg.end_red,   lvl);
            green_reg <= mix(cfg.start_green, cfg.end_green, lvl);
            blue_reg  <= mix(cfg.start_blue,  cfg.end_blue,  lvl);
        end
    end

    assign out_valid = vld_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;

endmodule

[hdl/gradient_map_pixel.sv]
// Top level of the two-colour gradient map, one RGB pixel per word.
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      s_pixel_red, s_pixel_green, s_pixel_blue
//   m_        out        m_valid / m_ready      m_mapped_red, m_mapped_green, m_mapped_blue
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One word per clock in and out while m_ready is high; the pipeline stages are sum, brightness
// multiply, gain multiply, offset and clamp, and colour blend.
// Synchronous active-low reset empties the pipeline and loads register defaults.
// Each stage stalls only when its successor is full, so bubbles close up
// and m_ready low holds the output word without losing anything.
module gradient_map_pixel (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [gmp_pkg::PIX_W-1:0]      s_pixel_red,
    input  logic [gmp_pkg::PIX_W-1:0]      s_pixel_green,
    input  logic [gmp_pkg::PIX_W-1:0]      s_pixel_blue,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [gmp_pkg::PIX_W-1:0]      m_mapped_red,
    output logic [gmp_pkg::PIX_W-1:0]      m_mapped_green,
    output logic [gmp_pkg::PIX_W-1:0]      m_mapped_blue,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gmp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gmp_pkg::*;

    gmp_cfg_t           cfg;
    logic               lvl_valid, lvl_ready;
    logic [LEVEL_W-1:0] lvl;

    gmp_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gmp_level u_level (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .gain      (cfg.gain),
        .offset    (cfg.offset),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_red    (s_pixel_red),
        .in_green  (s_pixel_green),
        .in_blue   (s_pixel_blue),
        .lvl_valid (lvl_valid),
        .lvl_ready (lvl_ready),
        .lvl       (lvl)
    );

    gmp_blend u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .lvl_valid (lvl_valid),
        .lvl_ready (lvl_ready),
        .lvl       (lvl),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_red   (m_mapped_red),
        .out_green (m_mapped_green),
        .out_blue  (m_mapped_blue)
    );

endmodule
